// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies; a file that uses them includes this header by name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define PTC_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ptc check failed");

// concurrent assertion on the usual clk_i and rst_ni
`define PTC_ASSERT(lbl, prop) `PTC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/ptc_pkg.sv =====
// shared constants, types and the resistance table of the thermistor readout
// no dependencies; used by the top level and the checker through scoped names
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int DATA_W      = 16;
  localparam int TEMP_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int TABLE_LEN   = 16;
  localparam int TABLE_IDX_W = 4;
  localparam int RES_W       = 13;
  localparam int FRAC_W      = 8;
  localparam int R_W         = RES_W + FRAC_W;
  localparam int DIFF_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DIV_BPS     = 3;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int STEP_DEGREES_DEF  = 10;

  localparam logic [DATA_W-1:0] SERIES_RESET    = 16'd3300;
  localparam logic [DATA_W-1:0] REF_RESET       = 16'd5100;
  localparam logic [TEMP_W-1:0] OVER_RANGE_CODE = 8'd111;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INTERP = 2'd0,
    STATUS_BELOW  = 2'd1,
    STATUS_OVER   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERIES = 1'b0,
    CFG_REF    = 1'b1
  } cfg_idx_e;

  // sensor resistance in ohms, 0 degC upwards in equal steps
  localparam logic [RES_W-1:0] RES_TABLE [TABLE_LEN] = '{
    13'd1630, 13'd1722, 13'd1922, 13'd2080, 13'd2245, 13'd2417, 13'd2597, 13'd2785,
    13'd2980, 13'd3182, 13'd3392, 13'd3607, 13'd3817, 13'd4008, 13'd4166, 13'd4280
  };

  // table entry scaled to the q8 resistance format
  function automatic logic [R_W-1:0] res_q8(input logic [TABLE_IDX_W-1:0] idx);
    res_q8 = {RES_TABLE[idx], {FRAC_W{1'b0}}};
  endfunction

endpackage

// ===== rtl/ptc_div_pipe.sv =====
// pipelined restoring divider, BPS quotient bits per register stage
// depends on nothing but its parameters; instantiated twice by the top level
`timescale 1ns / 1ps

module ptc_div_pipe #(
  parameter int DEN_W  = 16,
  parameter int Q_W    = 21,
  parameter int SIDE_W = 2,
  parameter int BPS    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  hi_i,
  input  logic [Q_W-1:0]    lo_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int STAGES = (Q_W + BPS - 1) / BPS;

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_in;
  logic [DEN_W-1:0]  rem_in  [STAGES];
  logic [DEN_W-1:0]  rem_d   [STAGES];
  logic [DEN_W-1:0]  rem_q   [STAGES];
  logic [DEN_W-1:0]  den_in  [STAGES];
  logic [DEN_W-1:0]  den_q   [STAGES];
  logic [Q_W-1:0]    lo_in   [STAGES];
  logic [Q_W-1:0]    lo_q    [STAGES];
  logic [Q_W-1:0]    quot_in [STAGES];
  logic [Q_W-1:0]    quot_d  [STAGES];
  logic [Q_W-1:0]    quot_q  [STAGES];
  logic [SIDE_W-1:0] side_in [STAGES];
  logic [SIDE_W-1:0] side_q  [STAGES];

  always_comb begin
    vld_in[0]  = valid_i;
    rem_in[0]  = hi_i;
    den_in[0]  = den_i;
    lo_in[0]   = lo_i;
    quot_in[0] = '0;
    side_in[0] = side_i;
    for (int s = 1; s < STAGES; s++) begin
      vld_in[s]  = vld_q[s-1];
      rem_in[s]  = rem_q[s-1];
      den_in[s]  = den_q[s-1];
      lo_in[s]   = lo_q[s-1];
      quot_in[s] = quot_q[s-1];
      side_in[s] = side_q[s-1];
    end
  end

  // compare and subtract steps of each stage
  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] r;
    logic [Q_W-1:0]   q;
    int               k;
    for (int s = 0; s < STAGES; s++) begin
      r = rem_in[s];
      q = quot_in[s];
      for (int b = 0; b < BPS; b++) begin
        k = Q_W - 1 - (s * BPS + b);
        if (k >= 0) begin
          trial = {r, lo_in[s][k]};
          if (trial >= {1'b0, den_in[s]}) begin
            trial = trial - {1'b0, den_in[s]};
            q[k]  = 1'b1;
          end
          r = trial[DEN_W-1:0];
        end
      end
      rem_d[s]  = r;
      quot_d[s] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < STAGES; s++) begin
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= den_in[s];
        lo_q[s]   <= lo_in[s];
        quot_q[s] <= quot_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign quot_o  = quot_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

// ===== rtl/ptc_adc_to_temperature.sv =====
// Thermistor divider readout: one millivolt sample in, one temperature out.
// The sensor resistance mv*series/(ref-mv) is formed in q8 fixed point by a
// pipelined restoring divider, placed in the resistance table and interpolated
// by a second, shorter divider; both take three quotient bits a stage. A sample
// is taken every cycle while the output is not stalled. A result waiting at
// the output stalls the whole pipeline without losing anything.
// Configuration writes take effect at once and belong between bursts.
// depends on ptc_pkg and ptc_div_pipe
`timescale 1ns / 1ps

module ptc_adc_to_temperature #(
  parameter int TABLE_ENTRIES = ptc_pkg::TABLE_ENTRIES_DEF,
  parameter int STEP_DEGREES  = ptc_pkg::STEP_DEGREES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptc_pkg::DATA_W-1:0]     cfg_wdata_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic [ptc_pkg::DATA_W-1:0]     sample_mv_i,
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic [ptc_pkg::TEMP_W-1:0]     temperature_c_o,
  output logic [ptc_pkg::STATUS_W-1:0]   range_status_o
);

  localparam int N_EFF  = (TABLE_ENTRIES > ptc_pkg::TABLE_LEN) ? ptc_pkg::TABLE_LEN :
                          ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int IDX_W  = $clog2(N_EFF);
  localparam int QW     = $clog2(STEP_DEGREES + 1);
  localparam int NUM2_W = ptc_pkg::DIFF_W + QW;
  localparam int SUM_RAW = $clog2(N_EFF * STEP_DEGREES + 1);
  localparam int SUM_W  = (SUM_RAW > ptc_pkg::TEMP_W) ? SUM_RAW : ptc_pkg::TEMP_W;
  localparam int HI_LSB = ptc_pkg::R_W - ptc_pkg::FRAC_W;
  localparam int OVF_W  = ptc_pkg::PROD_W - HI_LSB;
  localparam int SIDE2_W = ptc_pkg::STATUS_W + SUM_W;

  logic advance;

  // configuration registers
  logic [ptc_pkg::DATA_W-1:0] series_q;
  logic [ptc_pkg::DATA_W-1:0] ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= ptc_pkg::SERIES_RESET;
      ref_q    <= ptc_pkg::REF_RESET;
    end else if (cfg_we_i) begin
      case (ptc_pkg::cfg_idx_e'(cfg_index_i))
        ptc_pkg::CFG_SERIES: series_q <= cfg_wdata_i;
        ptc_pkg::CFG_REF:    ref_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance        = !result_valid_o || result_ready_i;
  assign sample_ready_o = advance;

  // stage 1: product, divider denominator and range status
  logic                         s1_vld_q;
  logic [ptc_pkg::PROD_W-1:0]   s1_prod_q;
  logic [ptc_pkg::DATA_W-1:0]   s1_den_q;
  ptc_pkg::status_e             s1_st_q;
  ptc_pkg::status_e             s1_st_d;

  always_comb begin
    if (sample_mv_i > ref_q) begin
      s1_st_d = ptc_pkg::STATUS_BELOW;
    end else if (sample_mv_i == ref_q) begin
      s1_st_d = ptc_pkg::STATUS_OVER;
    end else begin
      s1_st_d = ptc_pkg::STATUS_INTERP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_prod_q <= ptc_pkg::PROD_W'(sample_mv_i) * ptc_pkg::PROD_W'(series_q);
      s1_den_q  <= ref_q - sample_mv_i;
      s1_st_q   <= s1_st_d;
    end
  end

  // stage 2: quotient overflow check and divider operands
  logic                       s2_vld_q;
  logic [ptc_pkg::DATA_W-1:0] s2_hi_q;
  logic [ptc_pkg::R_W-1:0]    s2_lo_q;
  logic [ptc_pkg::DATA_W-1:0] s2_den_q;
  ptc_pkg::status_e           s2_st_q;
  logic                       s2_ovf;

  assign s2_ovf = s1_prod_q[ptc_pkg::PROD_W-1:HI_LSB] >= OVF_W'(s1_den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_hi_q  <= s1_prod_q[HI_LSB +: ptc_pkg::DATA_W];
      s2_lo_q  <= {s1_prod_q[HI_LSB-1:0], {ptc_pkg::FRAC_W{1'b0}}};
      s2_den_q <= s1_den_q;
      if (s1_st_q == ptc_pkg::STATUS_INTERP && s2_ovf) begin
        s2_st_q <= ptc_pkg::STATUS_OVER;
      end else begin
        s2_st_q <= s1_st_q;
      end
    end
  end

  // resistance divider
  logic                         d1_vld;
  logic [ptc_pkg::R_W-1:0]      d1_r;
  logic [ptc_pkg::STATUS_W-1:0] d1_side;

  ptc_div_pipe #(
    .DEN_W  (ptc_pkg::DATA_W),
    .Q_W    (ptc_pkg::R_W),
    .SIDE_W (ptc_pkg::STATUS_W),
    .BPS    (ptc_pkg::DIV_BPS)
  ) u_div_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (s2_vld_q),
    .hi_i    (s2_hi_q),
    .lo_i    (s2_lo_q),
    .den_i   (s2_den_q),
    .side_i  (s2_st_q),
    .valid_o (d1_vld),
    .quot_o  (d1_r),
    .side_o  (d1_side)
  );

  // stage 3: table segment search
  logic [N_EFF-1:0]           hit;
  logic [IDX_W-1:0]           seg_idx;
  logic [IDX_W-1:0]           seg_prev;
  logic [ptc_pkg::R_W-1:0]    seg_lo;
  logic [ptc_pkg::R_W-1:0]    seg_hi;
  ptc_pkg::status_e           s3_st_d;
  logic                       s3_vld_q;
  ptc_pkg::status_e           s3_st_q;
  logic [SUM_W-1:0]           s3_base_q;
  logic [ptc_pkg::DIFF_W-1:0] s3_diff_q;
  logic [ptc_pkg::DIFF_W-1:0] s3_dd_q;

  always_comb begin
    hit = '0;
    for (int i = 1; i < N_EFF; i++) begin
      hit[i] = ptc_pkg::res_q8(ptc_pkg::TABLE_IDX_W'(i)) >= d1_r;
    end
    seg_idx = '0;
    for (int i = N_EFF - 1; i >= 1; i--) begin
      if (hit[i]) begin
        seg_idx = IDX_W'(i);
      end
    end
    seg_prev = seg_idx - 1'b1;
    seg_lo   = ptc_pkg::res_q8(ptc_pkg::TABLE_IDX_W'(seg_prev));
    seg_hi   = ptc_pkg::res_q8(ptc_pkg::TABLE_IDX_W'(seg_idx));
    if (ptc_pkg::status_e'(d1_side) != ptc_pkg::STATUS_INTERP) begin
      s3_st_d = ptc_pkg::status_e'(d1_side);
    end else if (d1_r <= ptc_pkg::res_q8('0)) begin
      s3_st_d = ptc_pkg::STATUS_BELOW;
    end else if (!(|hit)) begin
      s3_st_d = ptc_pkg::STATUS_OVER;
    end else begin
      s3_st_d = ptc_pkg::STATUS_INTERP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (advance) begin
      s3_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_st_q   <= s3_st_d;
      s3_base_q <= SUM_W'(SUM_W'(seg_prev) * SUM_W'(STEP_DEGREES));
      s3_diff_q <= ptc_pkg::DIFF_W'(d1_r - seg_lo);
      s3_dd_q   <= ptc_pkg::DIFF_W'(seg_hi - seg_lo);
    end
  end

  // stage 4: scale the offset into the segment by the step
  logic                       s4_vld_q;
  ptc_pkg::status_e           s4_st_q;
  logic [SUM_W-1:0]           s4_base_q;
  logic [NUM2_W-1:0]          s4_num_q;
  logic [ptc_pkg::DIFF_W-1:0] s4_dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (advance) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_st_q   <= s3_st_q;
      s4_base_q <= s3_base_q;
      s4_num_q  <= NUM2_W'(NUM2_W'(s3_diff_q) * NUM2_W'(STEP_DEGREES));
      s4_dd_q   <= s3_dd_q;
    end
  end

  // interpolation divider
  logic               d2_vld;
  logic [QW-1:0]      d2_q;
  logic [SIDE2_W-1:0] d2_side;

  ptc_div_pipe #(
    .DEN_W  (ptc_pkg::DIFF_W),
    .Q_W    (QW),
    .SIDE_W (SIDE2_W),
    .BPS    (ptc_pkg::DIV_BPS)
  ) u_div_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (s4_vld_q),
    .hi_i    (s4_num_q[NUM2_W-1:QW]),
    .lo_i    (s4_num_q[QW-1:0]),
    .den_i   (s4_dd_q),
    .side_i  ({s4_st_q, s4_base_q}),
    .valid_o (d2_vld),
    .quot_o  (d2_q),
    .side_o  (d2_side)
  );

  // output register
  ptc_pkg::status_e            d2_st;
  logic [SUM_W-1:0]            d2_sum;
  logic [ptc_pkg::TEMP_W-1:0]  temp_d;
  logic                        out_vld_q;
  logic [ptc_pkg::TEMP_W-1:0]  temp_q;
  ptc_pkg::status_e            status_q;

  assign d2_st  = ptc_pkg::status_e'(d2_side[SIDE2_W-1:SUM_W]);
  assign d2_sum = d2_side[SUM_W-1:0] + SUM_W'(d2_q);

  always_comb begin
    case (d2_st)
      ptc_pkg::STATUS_BELOW: temp_d = '0;
      ptc_pkg::STATUS_OVER:  temp_d = ptc_pkg::OVER_RANGE_CODE;
      default:               temp_d = d2_sum[ptc_pkg::TEMP_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      temp_q   <= temp_d;
      status_q <= d2_st;
    end
  end

  assign result_valid_o  = out_vld_q;
  assign temperature_c_o = temp_q;
  assign range_status_o  = status_q;

endmodule

// ===== rtl/ptc_chk.sv =====
// port-level checks of the thermistor readout, bound to the top level
// depends on ptc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptc_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         sample_ready_i,
  input logic                         result_valid_i,
  input logic                         result_ready_i,
  input logic [ptc_pkg::TEMP_W-1:0]   temperature_c_i,
  input logic [ptc_pkg::STATUS_W-1:0] range_status_i
);

  `PTC_ASSERT(a_over_code, (result_valid_i && (range_status_i == ptc_pkg::STATUS_OVER)) |-> (temperature_c_i == ptc_pkg::OVER_RANGE_CODE))
  `PTC_ASSERT(a_below_zero, (result_valid_i && (range_status_i == ptc_pkg::STATUS_BELOW)) |-> (temperature_c_i == '0))
  `PTC_ASSERT(a_ready_free, (!result_valid_i || result_ready_i) |-> sample_ready_i)
  `PTC_ASSERT(a_out_hold, (result_valid_i && !result_ready_i) |=> (result_valid_i && $stable(temperature_c_i) && $stable(range_status_i)))

endmodule

bind ptc_adc_to_temperature ptc_chk u_ptc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .sample_ready_i  (sample_ready_o),
  .result_valid_i  (result_valid_o),
  .result_ready_i  (result_ready_i),
  .temperature_c_i (temperature_c_o),
  .range_status_i  (range_status_o)
);

// ===== dv/tb.sv =====
// self-checking testbench for ptc_adc_to_temperature: millivolt samples are
// driven through the request channel, each reading is predicted and checked
// depends on ptc_pkg and the block under test
`timescale 1ns / 1ps

module tb;
  import ptc_pkg::*;

  localparam int TABLE_N       = 16;
  localparam int STEP_DEG      = 10;
  localparam int PIPE_LATENCY  = 14;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_AT       = 25;
  localparam int HOLD_CYCLES   = 200;
  localparam int CALM_FROM     = 40;
  localparam int CALM_TO       = 140;

  localparam longint unsigned OHMS_TABLE [TABLE_N] = '{
    1630, 1722, 1922, 2080, 2245, 2417, 2597, 2785,
    2980, 3182, 3392, 3607, 3817, 4008, 4166, 4280
  };

  typedef enum logic [1:0] {REQ_SAMPLE, REQ_WRITE, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e        kind;
    cfg_idx_e         index;
    logic [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    status_e           status;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;
  logic                 sample_valid_i = 1'b0;
  logic                 sample_ready_o;
  logic [DATA_W-1:0]    sample_mv_i = '0;
  logic                 result_valid_o;
  logic                 result_ready_i = 1'b0;
  logic [TEMP_W-1:0]    temperature_c_o;
  logic [STATUS_W-1:0]  range_status_o;

  request_t pending_requests [$];
  reading_t expected_readings [$];

  logic [DATA_W-1:0] series_ohms = SERIES_RESET;
  logic [DATA_W-1:0] ref_mv = REF_RESET;
  logic [DATA_W-1:0] plan_series = SERIES_RESET;
  logic [DATA_W-1:0] plan_ref = REF_RESET;

  logic sample_taken = 1'b0;
  int   samples_sent = 0;
  int   readings_seen = 0;
  int   settle_count = 0;
  int   hold_count = 0;
  bit   held = 1'b0;
  int   quiet_cycles = 0;
  int   errors = 0;

  ptc_adc_to_temperature DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_valid_i  (sample_valid_i),
    .sample_ready_o  (sample_ready_o),
    .sample_mv_i     (sample_mv_i),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .temperature_c_o (temperature_c_o),
    .range_status_o  (range_status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic reading_t predict_reading(input logic [DATA_W-1:0] mv);
    reading_t        rd;
    longint unsigned mv64;
    longint unsigned ref64;
    longint unsigned ohms_q8;
    longint unsigned lo;
    longint unsigned span;
    longint unsigned num;
    int              seg;
    mv64 = mv;
    ref64 = ref_mv;
    rd.temp = '0;
    rd.status = STATUS_BELOW;
    if (mv64 == ref64) begin
      rd.temp = OVER_RANGE_CODE;
      rd.status = STATUS_OVER;
    end else if (mv64 < ref64) begin
      ohms_q8 = (mv64 * longint'(series_ohms) * 64'd256) / (ref64 - mv64);
      if (ohms_q8 > OHMS_TABLE[0] * 256) begin
        seg = 1;
        while (seg < TABLE_N && OHMS_TABLE[seg] * 256 < ohms_q8) seg++;
        if (seg >= TABLE_N) begin
          rd.temp = OVER_RANGE_CODE;
          rd.status = STATUS_OVER;
        end else begin
          lo = OHMS_TABLE[seg-1] * 256;
          span = (OHMS_TABLE[seg] - OHMS_TABLE[seg-1]) * 256;
          num = longint'(seg - 1) * STEP_DEG * span + STEP_DEG * (ohms_q8 - lo);
          rd.temp = TEMP_W'(num / span);
          rd.status = STATUS_INTERP;
        end
      end
    end
    return rd;
  endfunction

  // divider voltage that puts the sensor at the given resistance
  function automatic int mv_for_ohms(input longint unsigned ohms);
    longint unsigned v;
    v = (ohms * plan_ref) / (ohms + plan_series);
    if (v > 65535) v = 65535;
    return int'(v);
  endfunction

  function automatic void push_sample(input int v);
    request_t r;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    r.kind = REQ_SAMPLE;
    r.index = CFG_SERIES;
    r.value = DATA_W'(v);
    pending_requests.push_back(r);
  endfunction

  function automatic void push_write(input cfg_idx_e idx, input int v);
    request_t r;
    r.kind = REQ_WRITE;
    r.index = idx;
    r.value = DATA_W'(v);
    if (idx == CFG_SERIES) plan_series = DATA_W'(v);
    else plan_ref = DATA_W'(v);
    pending_requests.push_back(r);
  endfunction

  function automatic void push_drain();
    request_t r;
    r.kind = REQ_DRAIN;
    r.index = CFG_SERIES;
    r.value = '0;
    pending_requests.push_back(r);
  endfunction

  // mostly voltages in and around the table, the rest near the reference, near zero, at the rails or anywhere
  function automatic void push_random_samples(input int count);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 60)
        push_sample(mv_for_ohms($urandom_range(4400, 1500)) + int'($urandom_range(6)) - 3);
      else if (roll < 72)
        push_sample(int'(plan_ref) + int'($urandom_range(4)) - 2);
      else if (roll < 90)
        push_sample(int'($urandom_range(65535)));
      else if (roll < 95)
        push_sample(int'($urandom_range(16)));
      else
        push_sample($urandom_range(1) ? 65535 : 0);
    end
  endfunction

  initial begin
    int sel [5];
    sel = '{0, 1, 7, 14, 15};
    // directed at the reset configuration
    push_sample(0);
    push_sample(1);
    push_sample(65535);
    push_sample(32768);
    push_sample(32767);
    push_sample(int'(plan_ref));
    push_sample(int'(plan_ref) - 1);
    push_sample(int'(plan_ref) + 1);
    foreach (sel[k]) begin
      push_sample(mv_for_ohms(OHMS_TABLE[sel[k]]));
      push_sample(mv_for_ohms(OHMS_TABLE[sel[k]]) + 1);
    end
    push_sample(mv_for_ohms(OHMS_TABLE[TABLE_N-1]) + 2);
    push_random_samples(110);
    push_drain();
    push_random_samples(20);

    push_write(CFG_SERIES, 65535);
    push_write(CFG_REF, 65535);
    push_sample(65535);
    push_sample(65534);
    push_sample(0);
    push_random_samples(40);

    push_write(CFG_SERIES, 1);
    push_write(CFG_REF, 1);
    push_sample(0);
    push_sample(1);
    push_sample(2);
    push_random_samples(12);

    // zero series resistor
    push_write(CFG_SERIES, 0);
    push_write(CFG_REF, 5100);
    push_sample(2000);
    push_random_samples(15);

    repeat (4) begin
      push_write(CFG_SERIES, $urandom_range(65535, 1));
      push_write(CFG_REF, $urandom_range(65535, 1));
      push_random_samples(40);
    end

    push_write(CFG_SERIES, int'(SERIES_RESET));
    push_write(CFG_REF, int'(REF_RESET));
    push_random_samples(50);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_requests.size() != 0 || sample_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  always @(negedge clk_i) begin : drive
    logic                 valid_n;
    logic [DATA_W-1:0]    mv_n;
    logic                 we_n;
    logic [CFG_IDX_W-1:0] index_n;
    logic [DATA_W-1:0]    wdata_n;
    bit                   calm;
    if (rst_ni) begin
      valid_n = sample_valid_i && !sample_taken;
      mv_n = sample_mv_i;
      we_n = 1'b0;
      index_n = cfg_index_i;
      wdata_n = cfg_wdata_i;
      calm = samples_sent >= CALM_FROM && samples_sent < CALM_TO;
      if (!valid_n && pending_requests.size() != 0) begin
        case (pending_requests[0].kind)
          REQ_SAMPLE: begin
            if (calm || $urandom_range(99) >= 11) begin
              valid_n = 1'b1;
              mv_n = pending_requests[0].value;
              void'(pending_requests.pop_front());
              samples_sent++;
            end
          end
          REQ_WRITE: begin
            if (expected_readings.size() == 0) begin
              if (settle_count < SETTLE_CYCLES) begin
                settle_count++;
              end else begin
                settle_count = 0;
                we_n = 1'b1;
                index_n = pending_requests[0].index;
                wdata_n = pending_requests[0].value;
                if (pending_requests[0].index == CFG_SERIES) series_ohms = wdata_n;
                else ref_mv = wdata_n;
                void'(pending_requests.pop_front());
              end
            end
          end
          REQ_DRAIN: begin
            if (expected_readings.size() == 0) void'(pending_requests.pop_front());
          end
          default: ;
        endcase
      end
      sample_valid_i <= valid_n;
      sample_mv_i <= mv_n;
      cfg_we_i <= we_n;
      cfg_index_i <= index_n;
      cfg_wdata_i <= wdata_n;
    end
  end

  always @(negedge clk_i) begin : receive
    bit calm;
    if (rst_ni) begin
      calm = readings_seen >= CALM_FROM && readings_seen < CALM_TO;
      if (hold_count > 0) begin
        hold_count--;
        result_ready_i <= 1'b0;
      end else if (readings_seen >= HOLD_AT && !held) begin
        // long hold-off so the pipeline backs up into the request side
        held = 1'b1;
        hold_count = HOLD_CYCLES;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= calm || $urandom_range(99) >= 11;
      end
    end
  end

  always @(posedge clk_i) begin : observe
    reading_t want;
    bit       moved;
    if (rst_ni) begin
      moved = 1'b0;
      sample_taken <= sample_valid_i && sample_ready_o;
      if (sample_valid_i && sample_ready_o) begin
        expected_readings.push_back(predict_reading(sample_mv_i));
        moved = 1'b1;
      end
      if (result_valid_o && result_ready_i) begin
        moved = 1'b1;
        readings_seen++;
        if (expected_readings.size() == 0) begin
          $error("reading with no request pending: temperature_c %0d range_status %0d",
                 temperature_c_o, range_status_o);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (temperature_c_o !== want.temp) begin
            $error("temperature_c expected %0d got %0d", want.temp, temperature_c_o);
            errors++;
          end
          if (range_status_o !== want.status) begin
            $error("range_status expected %0d got %0d", want.status, range_status_o);
            errors++;
          end
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_div_pipe.sv
rtl/ptc_adc_to_temperature.sv
rtl/ptc_chk.sv
dv/tb.sv
